// ----- design/dspg_pkg.sv -----
// ----------------------------------------------------------------------------
// dspg_pkg: shared types and constants of the dda step pulse generator
// field widths, beat kinds and the control struct between controller and lanes
// ----------------------------------------------------------------------------
package dspg_pkg;

    localparam int KIND_W         = 2;
    localparam int MOTOR_W        = 2;
    localparam int INC_W          = 31;
    localparam int CORR_W         = 20;
    localparam int TICKS_W        = 24;
    localparam int DEPTH_W        = 31;
    localparam int ACC_W          = 32;
    localparam int MASK_W         = 4;
    localparam int DEF_MOTOR_COUNT = 4;

    // unity scale factor in Q4.16
    localparam logic [CORR_W-1:0] CORR_ONE = CORR_W'(20'h10000);

    // beat kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STAGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DWELL = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [MOTOR_W-1:0] motor;
        logic [INC_W-1:0]   increment;
        logic               direction;
        logic               correct_flag;
        logic [CORR_W-1:0]  correction;
        logic [TICKS_W-1:0] ticks;
        logic [DEPTH_W-1:0] depth;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] step_mask;
        logic [MASK_W-1:0] dir_mask;
        logic              busy_res;
        logic              segment_done;
        logic              rejected;
    } t_out_item;

    // commands from the controller to every motor lane
    typedef struct packed {
        logic               tick_run;
        logic               start_line;
        logic [DEPTH_W-1:0] depth;
    } t_lane_ctl;

    // what one lane hands back
    typedef struct packed {
        logic step;
        logic dir;
    } t_lane_res;

endpackage

// ----- design/dspg_if.sv -----
// ----------------------------------------------------------------------------
// dspg_if: valid/ready channels of the dda step pulse generator
// input beat channel and result beat channel
// ----------------------------------------------------------------------------
interface dspg_in_if;
    import dspg_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [MOTOR_W-1:0] motor;
    logic [INC_W-1:0]   increment;
    logic               direction;
    logic               correct_flag;
    logic [CORR_W-1:0]  correction;
    logic [TICKS_W-1:0] ticks;
    logic [DEPTH_W-1:0] depth;

    modport source (
        output valid, kind, motor, increment, direction, correct_flag,
               correction, ticks, depth,
        input  ready
    );
    modport sink (
        input  valid, kind, motor, increment, direction, correct_flag,
               correction, ticks, depth,
        output ready
    );
endinterface

interface dspg_out_if;
    import dspg_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] step_mask;
    logic [MASK_W-1:0] dir_mask;
    logic              busy_res;
    logic              segment_done;
    logic              rejected;

    modport source (
        output valid, step_mask, dir_mask, busy_res, segment_done, rejected,
        input  ready
    );
    modport sink (
        input  valid, step_mask, dir_mask, busy_res, segment_done, rejected,
        output ready
    );
endinterface

// ----- design/dspg_ctrl.sv -----
// ----------------------------------------------------------------------------
// dspg_ctrl: segment controller
// tick down counter, run depth, dwell flag, start decode and rejection
// ----------------------------------------------------------------------------
module dspg_ctrl #(
    parameter int MOTOR_COUNT = dspg_pkg::DEF_MOTOR_COUNT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  dspg_pkg::t_in_item        i_item,
    output dspg_pkg::t_lane_ctl       o_ctl,
    output logic [MOTOR_COUNT-1:0]    o_stage_sel,
    output logic                      o_busy,
    output logic                      o_done,
    output logic                      o_rejected
);
    import dspg_pkg::*;

    logic [TICKS_W-1:0] r_count, n_count;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_dwell, n_dwell;
    logic               w_busy;

    assign w_busy = (r_count != '0);

    always_comb begin
        n_count          = r_count;
        n_depth          = r_depth;
        n_dwell          = r_dwell;
        o_ctl.tick_run   = 1'b0;
        o_ctl.start_line = 1'b0;
        o_done           = 1'b0;
        o_rejected       = 1'b0;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            o_stage_sel[m] = i_fire && (i_item.kind == KIND_STAGE) &&
                             (int'(i_item.motor) == m);
        end
        if (i_fire) begin
            case (i_item.kind)
                KIND_TICK: begin
                    if (w_busy) begin
                        n_count        = r_count - TICKS_W'(1);
                        o_done         = (n_count == '0);
                        o_ctl.tick_run = !r_dwell;
                    end
                end
                KIND_STAGE: begin
                    // handled in the lanes
                end
                KIND_LINE, KIND_DWELL: begin
                    if (w_busy) begin
                        o_rejected = 1'b1;
                    end else if (i_item.kind == KIND_LINE) begin
                        n_count          = i_item.ticks;
                        n_depth          = i_item.depth;
                        n_dwell          = 1'b0;
                        o_ctl.start_line = 1'b1;
                    end else begin
                        n_count = i_item.ticks;
                        n_dwell = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // a line start reloads with the new depth, ticks use the running one
        o_ctl.depth = o_ctl.start_line ? i_item.depth : r_depth;
        o_busy      = (n_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_depth <= '0;
            r_dwell <= 1'b0;
        end else begin
            r_count <= n_count;
            r_depth <= n_depth;
            r_dwell <= n_dwell;
        end
    end

endmodule

// ----- design/dspg_lane.sv -----
// ----------------------------------------------------------------------------
// dspg_lane: one motor lane
// staged values, run increment, accumulator with correction scaling
// ----------------------------------------------------------------------------
module dspg_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_stage,
    input  dspg_pkg::t_in_item   i_item,
    input  dspg_pkg::t_lane_ctl  i_ctl,
    output dspg_pkg::t_lane_res  o_res
);
    import dspg_pkg::*;

    localparam int PROD_W = ACC_W + CORR_W;
    localparam int SHR_W  = PROD_W - 16;

    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [INC_W-1:0]  r_run_inc;
    logic [INC_W-1:0]  r_stg_inc;
    logic              r_stg_dir;
    logic              r_stg_cflag;
    logic [CORR_W-1:0] r_stg_corr;
    logic              r_prev_dir;

    logic [ACC_W-1:0]  w_sum;
    logic              w_tick_step;
    logic [ACC_W-1:0]  w_tick_acc;
    logic [ACC_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [SHR_W-1:0]  w_shr;
    logic              w_ovf;
    logic [ACC_W-1:0]  w_sat;
    logic [ACC_W-1:0]  w_scaled;
    logic [ACC_W-1:0]  w_start_acc;
    logic              w_load;

    // tick: add increment, step and pull back by depth when above zero
    assign w_sum       = r_acc + {1'b0, r_run_inc};
    assign w_tick_step = (w_sum != '0) && !w_sum[ACC_W-1];
    assign w_tick_acc  = w_tick_step ? (w_sum - {1'b0, i_ctl.depth}) : w_sum;

    // start: scale magnitude by Q4.16, truncate toward zero, saturate
    assign w_mag   = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;
    assign w_prod  = PROD_W'(w_mag) * PROD_W'(r_stg_corr);
    assign w_shr   = w_prod[PROD_W-1:16];
    assign w_ovf   = (w_shr[SHR_W-1:ACC_W-1] != '0);

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            w_sat = w_ovf ? {1'b1, {(ACC_W-1){1'b0}}} : (~w_shr[ACC_W-1:0] + ACC_W'(1));
        end else begin
            w_sat = w_ovf ? {1'b0, {(ACC_W-1){1'b1}}} : w_shr[ACC_W-1:0];
        end
    end

    assign w_scaled    = r_stg_cflag ? w_sat : r_acc;
    // direction change reload, modulo 2^32
    assign w_start_acc = (r_stg_dir != r_prev_dir)
                       ? (ACC_W'(0) - ({1'b0, i_ctl.depth} + w_scaled)) : w_scaled;
    assign w_load      = i_ctl.start_line && (r_stg_inc != '0);

    always_comb begin
        n_acc = r_acc;
        if (w_load) begin
            n_acc = w_start_acc;
        end else if (i_ctl.tick_run) begin
            n_acc = w_tick_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_run_inc   <= '0;
            r_stg_inc   <= '0;
            r_stg_dir   <= 1'b0;
            r_stg_cflag <= 1'b0;
            r_stg_corr  <= CORR_ONE;
            r_prev_dir  <= 1'b0;
        end else begin
            r_acc <= n_acc;
            if (i_stage) begin
                r_stg_inc <= i_item.increment;
                r_stg_dir <= i_item.direction;
                if (i_item.correct_flag) begin
                    r_stg_cflag <= 1'b1;
                    r_stg_corr  <= i_item.correction;
                end
            end
            if (i_ctl.start_line) begin
                r_run_inc <= r_stg_inc;
            end
            if (w_load) begin
                r_stg_cflag <= 1'b0;
                r_prev_dir  <= r_stg_dir;
            end
        end
    end

    assign o_res.step = i_ctl.tick_run && w_tick_step;
    assign o_res.dir  = w_load ? r_stg_dir : r_prev_dir;

endmodule

// ----- design/dda_step_pulse_generator.sv -----
// ----------------------------------------------------------------------------
// dda_step_pulse_generator: multi-motor dda step pulse generator
// input register, one pass of controller and motor lanes, result register
// throughput: one beat per cycle while the result channel is not stalled; ticks, stage and start beats alike
// the critical path is the 32x20 correction multiply and saturation in a lane
// reset: synchronous active low; accumulators and counters clear, corrections
// return to unity, both beat registers empty
// ----------------------------------------------------------------------------
module dda_step_pulse_generator #(
    parameter int MOTOR_COUNT = dspg_pkg::DEF_MOTOR_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dspg_in_if.sink     i_item,
    dspg_out_if.source  o_res
);
    import dspg_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_item  r_in;
    // result register
    logic      r_out_valid;
    t_out_item r_out;

    logic      w_fire;
    logic      w_take;
    t_in_item  w_in;

    t_lane_ctl              w_ctl;
    logic [MOTOR_COUNT-1:0] w_stage_sel;
    logic                   w_busy;
    logic                   w_done;
    logic                   w_rejected;
    t_lane_res              w_lane_res [MOTOR_COUNT];
    logic [MASK_W-1:0]      w_step_mask;
    logic [MASK_W-1:0]      w_dir_mask;

    // the held beat is processed when the result register is free or draining
    assign w_fire       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || w_fire;
    assign w_take       = i_item.valid && i_item.ready;

    assign w_in.kind         = i_item.kind;
    assign w_in.motor        = i_item.motor;
    assign w_in.increment    = i_item.increment;
    assign w_in.direction    = i_item.direction;
    assign w_in.correct_flag = i_item.correct_flag;
    assign w_in.correction   = i_item.correction;
    assign w_in.ticks        = i_item.ticks;
    assign w_in.depth        = i_item.depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= w_in;
        end
    end

    // down counter, depth, dwell and start decode
    dspg_ctrl #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .o_ctl       (w_ctl),
        .o_stage_sel (w_stage_sel),
        .o_busy      (w_busy),
        .o_done      (w_done),
        .o_rejected  (w_rejected)
    );

    // one lane per motor, all updated in the same cycle
    for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
        dspg_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage_sel[m]),
            .i_item  (r_in),
            .i_ctl   (w_ctl),
            .o_res   (w_lane_res[m])
        );
    end

    // masks carry only the motors that fit in the result field
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < MOTOR_COUNT) begin : g_used
            assign w_step_mask[b] = w_lane_res[b].step;
            assign w_dir_mask[b]  = w_lane_res[b].dir;
        end else begin : g_unused
            assign w_step_mask[b] = 1'b0;
            assign w_dir_mask[b]  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.step_mask    <= w_step_mask;
            r_out.dir_mask     <= w_dir_mask;
            r_out.busy_res     <= w_busy;
            r_out.segment_done <= w_done;
            r_out.rejected     <= w_rejected;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.step_mask    = r_out.step_mask;
    assign o_res.dir_mask     = r_out.dir_mask;
    assign o_res.busy_res     = r_out.busy_res;
    assign o_res.segment_done = r_out.segment_done;
    assign o_res.rejected     = r_out.rejected;

`ifndef ASSERT_OFF
    // a segment that just ended leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_done |-> !w_busy)
        else $error("segment_done with counter still nonzero");

    // a rejected start moves nothing
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_rejected |-> (w_step_mask == '0) && !w_done && w_busy)
        else $error("rejected start produced activity");

    // steps only come from a tick of a running line segment
    a_step_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step_mask != '0) |-> w_fire && w_ctl.tick_run)
        else $error("step pulse outside a segment tick");

    // a held beat waits in the input register while the result is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_in))
        else $error("input register lost a stalled beat");
`endif

endmodule
